/* hdl/fs4mdc_pkg.sv */
package fs4mdc_pkg;

  localparam int RAW_W   = 8;
  localparam int SAMP_W  = 9;
  localparam int COEF_W  = 16;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 62;
  localparam int FIR_W   = 18;
  localparam int FIR_SH  = 7;
  localparam int XSC_SH  = 6;
  localparam int MEM_W   = 36;
  localparam int HALF_SH = 18;
  localparam int NODE_SH = 22;
  localparam int Y_W     = MEM_W + 3;
  localparam int OUT_W   = 20;
  localparam int OUT_SH  = 6;

  localparam logic signed [MUL_W-1:0] B0_Q22     = 24'sd4150272;
  localparam logic signed [MUL_W-1:0] NEG_A1_Q22 = 24'sd8300032;
  localparam logic signed [MUL_W-1:0] NEG_A2_Q22 = -24'sd4106752;

  localparam logic signed [ACC_W-1:0] FIR_RND  = ACC_W'(1) <<< (FIR_SH - 1);
  localparam logic signed [ACC_W-1:0] NODE_RND = ACC_W'(1) <<< (NODE_SH - 1);
  localparam logic signed [Y_W-1:0]   OUT_RND  = Y_W'(1) <<< (OUT_SH - 1);

  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef logic signed [MEM_W-1:0]  mem_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic shl;
  } mac_ctl_t;

  typedef struct packed {
    logic take;
    logic push;
  } hist_ctl_t;

  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [6:0] k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      7'd0:    c = -16'sd690;
      7'd1:    c = -16'sd3729;
      7'd2:    c = 16'sd571;
      7'd3:    c = 16'sd1625;
      7'd4:    c = 16'sd806;
      7'd5:    c = -16'sd2103;
      7'd6:    c = -16'sd2633;
      7'd7:    c = 16'sd2365;
      7'd8:    c = 16'sd10138;
      7'd9:    c = 16'sd13930;
      7'd10:   c = 16'sd10138;
      7'd11:   c = 16'sd2365;
      7'd12:   c = -16'sd2633;
      7'd13:   c = -16'sd2103;
      7'd14:   c = 16'sd806;
      7'd15:   c = 16'sd1625;
      7'd16:   c = 16'sd571;
      7'd17:   c = -16'sd3729;
      7'd18:   c = -16'sd690;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/fs4mdc_if.sv */
interface fs4mdc_in_if
  import fs4mdc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] sample_i;
  logic [RAW_W-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fs4mdc_out_if
  import fs4mdc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_i;
  logic signed [OUT_W-1:0] out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

/* hdl/fs4mdc_mac.sv */
module fs4mdc_mac
  import fs4mdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  base;

  assign prod_nxt = a * b;

  always_comb begin
    addend = ctl_r.shl ? (ACC_W'(prod_r) <<< HALF_SH) : ACC_W'(prod_r);
    base   = ctl_r.clr ? '0 : acc_r;
    acc_nxt = ctl_r.en ? base + addend : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* hdl/fs4mdc_hist.sv */
module fs4mdc_hist
  import fs4mdc_pkg::*;
#(
  parameter int DEPTH = 19,
  parameter int IW    = $clog2(DEPTH)
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  hist_ctl_t        ctl,
  input  logic [RAW_W-1:0] raw_i,
  input  logic [RAW_W-1:0] raw_q,
  input  logic [IW-1:0]    rd_idx,
  output samp_t            rd_i,
  output samp_t            rd_q,
  output samp_t            new_i,
  output samp_t            new_q
);

  logic [1:0]       rot_r;
  logic [RAW_W-1:0] vi;
  logic [RAW_W-1:0] vq;
  samp_t            new_i_r;
  samp_t            new_q_r;
  samp_t            hi_r [DEPTH];
  samp_t            hq_r [DEPTH];

  always_comb begin
    unique case (rot_r)
      2'd0: begin
        vi = raw_i;
        vq = raw_q;
      end
      2'd1: begin
        vi = ~raw_q;
        vq = raw_i;
      end
      2'd2: begin
        vi = ~raw_i;
        vq = ~raw_q;
      end
      default: begin
        vi = raw_q;
        vq = ~raw_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= '0;
    end else if (ctl.take) begin
      rot_r <= rot_r + 2'd1;
    end
  end

  // 2v-255: flip the top bit, append a one
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      new_i_r <= {~vi[RAW_W-1], vi[RAW_W-2:0], 1'b1};
      new_q_r <= {~vq[RAW_W-1], vq[RAW_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        hi_r[k] <= '0;
        hq_r[k] <= '0;
      end
    end else if (ctl.push) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        hi_r[k] <= hi_r[k+1];
        hq_r[k] <= hq_r[k+1];
      end
      hi_r[DEPTH-1] <= new_i_r;
      hq_r[DEPTH-1] <= new_q_r;
    end
  end

  assign rd_i  = hi_r[rd_idx];
  assign rd_q  = hq_r[rd_idx];
  assign new_i = new_i_r;
  assign new_q = new_q_r;

endmodule

/* hdl/fs4_mix_decimate_dc_block.sv */
// channel | dir | payload                          | handshake
// in_ch   | in  | sample_i[7:0], sample_q[7:0]     | valid/ready
// out_ch  | out | out_i[19:0] s, out_q[19:0] s      | valid/ready
//
// A non-emitting item only enters the history. An emitting item is paced
// by the single 24x24 multiply-accumulate unit: TAPS FIR products and 5
// biquad partial products per component, I then Q.
// Reset (rst_n low, synchronous) clears history, biquad state and phases.
// A finished result waits in the output register; the block then takes new
// items, stalling only if a second result is ready before the first is taken.
module fs4_mix_decimate_dc_block
  import fs4mdc_pkg::*;
#(
  parameter int TAPS       = 20,
  parameter int DECIMATION = 4
)
(
  input  logic             clk,
  input  logic             rst_n,
  fs4mdc_in_if.sink        in_ch,
  fs4mdc_out_if.source     out_ch
);

  localparam int DEPTH = TAPS - 1;
  localparam int HW    = $clog2(DEPTH);
  localparam int KW    = $clog2(TAPS);
  localparam int DW    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;
  localparam logic [3:0] S_FIR  = 4'd2;
  localparam logic [3:0] S_FDRN = 4'd3;
  localparam logic [3:0] S_FRND = 4'd4;
  localparam logic [3:0] S_BQ   = 4'd5;
  localparam logic [3:0] S_BDRN = 4'd6;
  localparam logic [3:0] S_NODE = 4'd7;
  localparam logic [3:0] S_YSUM = 4'd8;
  localparam logic [3:0] S_OSAT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic signed [MEM_W-1:0] MEM_MAX = {1'b0, {(MEM_W-1){1'b1}}};
  localparam logic signed [MEM_W-1:0] MEM_MIN = {1'b1, {(MEM_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [3:0]              state_r;
  logic [3:0]              state_nxt;
  logic [KW-1:0]           k_r;
  logic [KW-1:0]           k_nxt;
  logic [2:0]              j_r;
  logic [2:0]              j_nxt;
  logic                    p_r;
  logic                    p_nxt;
  logic [DW-1:0]           dec_r;
  logic [DW-1:0]           dec_nxt;
  logic                    out_v_r;
  logic                    out_v_nxt;
  logic signed [OUT_W-1:0] out_i_r;
  logic signed [OUT_W-1:0] out_q_r;
  logic signed [OUT_W-1:0] res_r [2];
  logic signed [FIR_W-1:0] f_r;
  mem_t                    t_r;
  logic signed [Y_W-1:0]   y_r;
  mem_t                    m0_r [2];
  mem_t                    m1_r [2];

  logic                    in_acc;
  logic                    out_load;
  logic                    k_last;
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a;
  logic signed [MUL_W-1:0] mac_b;
  logic signed [ACC_W-1:0] acc;
  hist_ctl_t               hist_ctl;
  samp_t                   rd_i;
  samp_t                   rd_q;
  samp_t                   new_i;
  samp_t                   new_q;
  samp_t                   tap_data;
  mem_t                    m0_cur;
  mem_t                    m1_cur;
  logic signed [ACC_W-1:0] fir_sum;
  logic signed [ACC_W-1:0] node_sum;
  mem_t                    node_sat;
  logic signed [Y_W-1:0]   out_sum;
  logic signed [OUT_W-1:0] out_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_v_r || out_ch.ready);
  assign k_last      = (k_r == KW'(TAPS - 1));
  assign m0_cur      = m0_r[p_r];
  assign m1_cur      = m1_r[p_r];

  assign hist_ctl.take = in_acc;
  assign hist_ctl.push = (state_r == S_PUSH) || out_load;

  fs4mdc_hist #(
    .DEPTH (DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hist_ctl),
    .raw_i  (in_ch.sample_i),
    .raw_q  (in_ch.sample_q),
    .rd_idx (k_r[HW-1:0]),
    .rd_i   (rd_i),
    .rd_q   (rd_q),
    .new_i  (new_i),
    .new_q  (new_q)
  );

  fs4mdc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  always_comb begin
    if (k_last) begin
      tap_data = p_r ? new_q : new_i;
    end else begin
      tap_data = p_r ? rd_q : rd_i;
    end
  end

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    if (state_r == S_FIR) begin
      mac_ctl.en  = 1'b1;
      mac_ctl.clr = (k_r == '0);
      mac_a       = MUL_W'(tap_coef(7'(k_r)));
      mac_b       = MUL_W'(tap_data);
    end else if (state_r == S_BQ) begin
      mac_ctl.en  = 1'b1;
      mac_ctl.clr = (j_r == 3'd0);
      mac_ctl.shl = (j_r == 3'd1) || (j_r == 3'd3);
      priority case (j_r)
        3'd0: begin
          mac_a = B0_Q22;
          mac_b = {f_r, {XSC_SH{1'b0}}};
        end
        3'd1: begin
          mac_a = NEG_A1_Q22;
          mac_b = {{(MUL_W-MEM_W+HALF_SH){m0_cur[MEM_W-1]}}, m0_cur[MEM_W-1:HALF_SH]};
        end
        3'd2: begin
          mac_a = NEG_A1_Q22;
          mac_b = {{(MUL_W-HALF_SH){1'b0}}, m0_cur[HALF_SH-1:0]};
        end
        3'd3: begin
          mac_a = NEG_A2_Q22;
          mac_b = {{(MUL_W-MEM_W+HALF_SH){m1_cur[MEM_W-1]}}, m1_cur[MEM_W-1:HALF_SH]};
        end
        default: begin
          mac_a = NEG_A2_Q22;
          mac_b = {{(MUL_W-HALF_SH){1'b0}}, m1_cur[HALF_SH-1:0]};
        end
      endcase
    end
  end

  always_comb begin
    fir_sum  = (acc + FIR_RND) >>> FIR_SH;
    node_sum = (acc + NODE_RND) >>> NODE_SH;
    if ((&node_sum[ACC_W-1:MEM_W-1]) || !(|node_sum[ACC_W-1:MEM_W-1])) begin
      node_sat = node_sum[MEM_W-1:0];
    end else begin
      node_sat = node_sum[ACC_W-1] ? MEM_MIN : MEM_MAX;
    end
    out_sum = (y_r + OUT_RND) >>> OUT_SH;
    if ((&out_sum[Y_W-1:OUT_W-1]) || !(|out_sum[Y_W-1:OUT_W-1])) begin
      out_sat = out_sum[OUT_W-1:0];
    end else begin
      out_sat = out_sum[Y_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    p_nxt     = p_r;
    dec_nxt   = dec_r;
    out_v_nxt = out_v_r;
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dec_nxt = (dec_r == DW'(DECIMATION - 1)) ? '0 : dec_r + DW'(1);
          if (dec_r == '0) begin
            state_nxt = S_FIR;
            k_nxt     = '0;
            p_nxt     = 1'b0;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        state_nxt = S_IDLE;
      end
      S_FIR: begin
        if (k_last) begin
          state_nxt = S_FDRN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_FDRN: begin
        state_nxt = S_FRND;
      end
      S_FRND: begin
        state_nxt = S_BQ;
        j_nxt     = '0;
      end
      S_BQ: begin
        if (j_r == 3'd4) begin
          state_nxt = S_BDRN;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_BDRN: begin
        state_nxt = S_NODE;
      end
      S_NODE: begin
        state_nxt = S_YSUM;
      end
      S_YSUM: begin
        state_nxt = S_OSAT;
      end
      S_OSAT: begin
        if (!p_r) begin
          p_nxt     = 1'b1;
          k_nxt     = '0;
          state_nxt = S_FIR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      p_r     <= 1'b0;
      dec_r   <= '0;
      out_v_r <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        m0_r[p] <= '0;
        m1_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
      dec_r   <= dec_nxt;
      out_v_r <= out_v_nxt;
      if (state_r == S_YSUM) begin
        m1_r[p_r] <= m0_cur;
        m0_r[p_r] <= t_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FRND) begin
      f_r <= fir_sum[FIR_W-1:0];
    end
    if (state_r == S_NODE) begin
      t_r <= node_sat;
    end
    if (state_r == S_YSUM) begin
      y_r <= Y_W'(t_r) - (Y_W'(m0_cur) <<< 1) + Y_W'(m1_cur);
    end
    if (state_r == S_OSAT) begin
      res_r[p_r] <= out_sat;
    end
    if (out_load) begin
      out_i_r <= res_r[0];
      out_q_r <= res_r[1];
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

endmodule
